>>> hdl/euler_to_quaternion_assert.svh
// ---------------------------------------------------------------------------
// euler_to_quaternion assertion macros
// shared property forms for the port-level checker
// ---------------------------------------------------------------------------
`ifndef EULER_TO_QUATERNION_ASSERT_SVH
`define EULER_TO_QUATERNION_ASSERT_SVH

// antecedent implies consequent in the same cycle, outside reset
`define E2Q_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition never holds outside reset
`define E2Q_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

>>> hdl/e2q_pkg.sv
// ---------------------------------------------------------------------------
// e2q_pkg
// shared constants and tables of the euler to quaternion pipeline
// ---------------------------------------------------------------------------
package e2q_pkg;

    localparam int CORDIC_STAGES_DEF = 24;
    localparam int FRACTION_BITS_DEF = 30;

    // angle, cordic and product widths
    localparam int ANGLE_W = 19;
    localparam int BANG_W  = 33;
    localparam int WORK_W  = 35;
    localparam int Q_W     = 32;
    localparam int SUM_W   = 36;

    localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 19'sd180000;

    // cordic start value: limit gain in q32
    localparam logic [31:0] GAIN_Q32 = 32'h9B74EDA8;

    // reciprocal of 45000 scaled by 2^48 for the half-angle scaling
    localparam int RECIP_SHIFT = 20;
    localparam logic [32:0] RECIP_K = 33'((64'd1 << 48) / 64'd45000);

    // arctangent table in binary angle units (2^32 per turn)
    localparam logic [31:0] ATAN_TURNS [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    // pipeline depth: 7 half-angle, stages plus rounding, 5 quaternion
    function automatic int e2q_latency(input int stages);
        return stages + 13;
    endfunction

endpackage

>>> hdl/e2q_half_angle.sv
// ---------------------------------------------------------------------------
// e2q_half_angle
// saturates a millidegree angle and scales it to a half-angle binary angle
// ---------------------------------------------------------------------------
module e2q_half_angle (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic signed [e2q_pkg::ANGLE_W-1:0]   angle_mdeg,
    output logic                                 out_valid,
    output logic signed [e2q_pkg::BANG_W-1:0]    out_angle
);
    import e2q_pkg::*;

    logic [6:0] valid_reg;

    logic                    s1_neg_reg;
    logic [17:0]             s1_mag_reg;
    logic                    s2_neg_reg;
    logic [2:0]              s2_k_reg;
    logic [15:0]             s2_r_reg;
    logic                    s3_neg_reg;
    logic [2:0]              s3_k_reg;
    logic [15:0]             s3_r_reg;
    logic [48:0]             s3_prod_reg;
    logic                    s4_neg_reg;
    logic [2:0]              s4_k_reg;
    logic [15:0]             s4_r_reg;
    logic [27:0]             s4_e_reg;
    logic                    s5_neg_reg;
    logic [2:0]              s5_k_reg;
    logic [15:0]             s5_r_reg;
    logic [27:0]             s5_e_reg;
    logic [44:0]             s5_ep_reg;
    logic                    s6_neg_reg;
    logic [30:0]             s6_q_reg;
    logic signed [BANG_W-1:0] s7_z_reg;

    logic signed [ANGLE_W-1:0] sat;
    logic [17:0]             mag_next;
    logic [2:0]              k_next;
    logic [15:0]             r_next;
    logic [48:0]             bias_sum;
    logic [44:0]             nprime;
    logic [44:0]             rem;
    logic                    corr;
    logic [30:0]             q_next;

    // saturate and take magnitude
    always_comb
    begin
        if (angle_mdeg > ANGLE_LIMIT)
        begin
            sat = ANGLE_LIMIT;
        end
        else if (angle_mdeg < -ANGLE_LIMIT)
        begin
            sat = -ANGLE_LIMIT;
        end
        else
        begin
            sat = angle_mdeg;
        end
        mag_next = sat[ANGLE_W-1] ? 18'(-sat) : 18'(sat);
    end

    // split magnitude into multiples of 45000 and a remainder
    always_comb
    begin
        if (s1_mag_reg >= 18'd180000)
        begin
            k_next = 3'd4;
            r_next = 16'(s1_mag_reg - 18'd180000);
        end
        else if (s1_mag_reg >= 18'd135000)
        begin
            k_next = 3'd3;
            r_next = 16'(s1_mag_reg - 18'd135000);
        end
        else if (s1_mag_reg >= 18'd90000)
        begin
            k_next = 3'd2;
            r_next = 16'(s1_mag_reg - 18'd90000);
        end
        else if (s1_mag_reg >= 18'd45000)
        begin
            k_next = 3'd1;
            r_next = 16'(s1_mag_reg - 18'd45000);
        end
        else
        begin
            k_next = 3'd0;
            r_next = 16'(s1_mag_reg);
        end
    end

    // quotient estimate, remainder check and compose
    assign bias_sum = s3_prod_reg + (49'd1 << (RECIP_SHIFT - 1));
    assign nprime   = {1'b0, s5_r_reg, 28'd22500};
    assign rem      = nprime - s5_ep_reg;
    assign corr     = (rem >= 45'd45000);
    assign q_next   = (31'(s5_k_reg) << 28) + 31'(s5_e_reg) + 31'(corr);

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[5:0], in_valid};
        end
    end

    // data stages
    always_ff @(posedge clk)
    begin
        s1_neg_reg  <= sat[ANGLE_W-1];
        s1_mag_reg  <= mag_next;
        s2_neg_reg  <= s1_neg_reg;
        s2_k_reg    <= k_next;
        s2_r_reg    <= r_next;
        s3_neg_reg  <= s2_neg_reg;
        s3_k_reg    <= s2_k_reg;
        s3_r_reg    <= s2_r_reg;
        s3_prod_reg <= 49'(s2_r_reg) * 49'(RECIP_K);
        s4_neg_reg  <= s3_neg_reg;
        s4_k_reg    <= s3_k_reg;
        s4_r_reg    <= s3_r_reg;
        s4_e_reg    <= 28'(bias_sum >> RECIP_SHIFT);
        s5_neg_reg  <= s4_neg_reg;
        s5_k_reg    <= s4_k_reg;
        s5_r_reg    <= s4_r_reg;
        s5_e_reg    <= s4_e_reg;
        s5_ep_reg   <= 45'(s4_e_reg) * 45'd45000;
        s6_neg_reg  <= s5_neg_reg;
        s6_q_reg    <= q_next;
        s7_z_reg    <= s6_neg_reg ? -$signed(BANG_W'(s6_q_reg)) : $signed(BANG_W'(s6_q_reg));
    end

    assign out_valid = valid_reg[6];
    assign out_angle = s7_z_reg;

endmodule

>>> hdl/e2q_cordic.sv
// ---------------------------------------------------------------------------
// e2q_cordic
// pipelined rotation cordic, one micro-rotation per stage, cos and sin in q30
// ---------------------------------------------------------------------------
module e2q_cordic #(
    parameter int CORDIC_STAGES = e2q_pkg::CORDIC_STAGES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic signed [e2q_pkg::BANG_W-1:0]  in_angle,
    output logic                               out_valid,
    output logic signed [e2q_pkg::Q_W-1:0]     out_cos,
    output logic signed [e2q_pkg::Q_W-1:0]     out_sin
);
    import e2q_pkg::*;

    logic signed [WORK_W-1:0] x_reg [CORDIC_STAGES];
    logic signed [WORK_W-1:0] y_reg [CORDIC_STAGES];
    logic signed [BANG_W-1:0] z_reg [CORDIC_STAGES];
    logic                     v_reg [CORDIC_STAGES];

    logic                     out_valid_reg;
    logic signed [Q_W-1:0]    cos_reg;
    logic signed [Q_W-1:0]    sin_reg;
    logic signed [WORK_W-1:0] x_round;
    logic signed [WORK_W-1:0] y_round;

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        logic signed [WORK_W-1:0] cur_x;
        logic signed [WORK_W-1:0] cur_y;
        logic signed [BANG_W-1:0] cur_z;
        logic                     cur_v;
        logic signed [WORK_W-1:0] dx;
        logic signed [WORK_W-1:0] dy;
        logic signed [BANG_W-1:0] at;

        // stage input select
        if (i == 0)
        begin : g_first
            assign cur_x = WORK_W'(GAIN_Q32);
            assign cur_y = '0;
            assign cur_z = in_angle;
            assign cur_v = in_valid;
        end
        else
        begin : g_next
            assign cur_x = x_reg[i-1];
            assign cur_y = y_reg[i-1];
            assign cur_z = z_reg[i-1];
            assign cur_v = v_reg[i-1];
        end

        // shifted terms and table angle
        assign dx = cur_y >>> i;
        assign dy = cur_x >>> i;
        assign at = BANG_W'(ATAN_TURNS[i % 32]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else
            begin
                v_reg[i] <= cur_v;
            end
        end

        // micro-rotation toward zero residual angle
        always_ff @(posedge clk)
        begin
            if (!cur_z[BANG_W-1])
            begin
                x_reg[i] <= cur_x - dx;
                y_reg[i] <= cur_y + dy;
                z_reg[i] <= cur_z - at;
            end
            else
            begin
                x_reg[i] <= cur_x + dx;
                y_reg[i] <= cur_y - dy;
                z_reg[i] <= cur_z + at;
            end
        end
    end

    // round q32 to q30
    assign x_round = (x_reg[CORDIC_STAGES-1] + WORK_W'(2)) >>> 2;
    assign y_round = (y_reg[CORDIC_STAGES-1] + WORK_W'(2)) >>> 2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= v_reg[CORDIC_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        cos_reg <= Q_W'(x_round);
        sin_reg <= Q_W'(y_round);
    end

    assign out_valid = out_valid_reg;
    assign out_cos   = cos_reg;
    assign out_sin   = sin_reg;

endmodule

>>> hdl/e2q_quat.sv
// ---------------------------------------------------------------------------
// e2q_quat
// zyx quaternion from half-angle cosines and sines, rounded and saturated
// ---------------------------------------------------------------------------
module e2q_quat #(
    parameter int FRACTION_BITS = e2q_pkg::FRACTION_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic signed [e2q_pkg::Q_W-1:0] cr,
    input  logic signed [e2q_pkg::Q_W-1:0] sr,
    input  logic signed [e2q_pkg::Q_W-1:0] cp,
    input  logic signed [e2q_pkg::Q_W-1:0] sp,
    input  logic signed [e2q_pkg::Q_W-1:0] cy,
    input  logic signed [e2q_pkg::Q_W-1:0] sy,
    output logic                           out_valid,
    output logic signed [e2q_pkg::Q_W-1:0] qw,
    output logic signed [e2q_pkg::Q_W-1:0] qx,
    output logic signed [e2q_pkg::Q_W-1:0] qy,
    output logic signed [e2q_pkg::Q_W-1:0] qz
);
    import e2q_pkg::*;

    localparam int RSH = 30 - FRACTION_BITS;
    localparam logic signed [SUM_W-1:0] HALF = (SUM_W'(1) <<< RSH) >>> 1;
    localparam logic signed [SUM_W-1:0] LIM  = SUM_W'(1) <<< FRACTION_BITS;

    logic [4:0] valid_reg;

    logic signed [63:0]    pa_reg, pb_reg, pc_reg, pd_reg;
    logic signed [Q_W-1:0] cy1_reg, sy1_reg, cy2_reg, sy2_reg;
    logic signed [Q_W-1:0] ra_reg, rb_reg, rc_reg, rd_reg;
    logic signed [63:0]    wa_reg, wb_reg, xa_reg, xb_reg;
    logic signed [63:0]    ya_reg, yb_reg, za_reg, zb_reg;
    logic signed [SUM_W-1:0] sw_reg, sx_reg, sy_reg, sz_reg;
    logic signed [Q_W-1:0] qw_reg, qx_reg, qy_reg, qz_reg;

    // round a q60 product back to q30
    function automatic logic signed [SUM_W-1:0] rnd30(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = (p + 64'sd536870912) >>> 30;
        return SUM_W'(t);
    endfunction

    // round to output fraction and clamp to plus or minus one
    function automatic logic signed [Q_W-1:0] fin(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] t;
        t = (v + HALF) >>> RSH;
        if (t > LIM)
        begin
            t = LIM;
        end
        else if (t < -LIM)
        begin
            t = -LIM;
        end
        return Q_W'(t);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    // products, rounding and sums
    always_ff @(posedge clk)
    begin
        pa_reg  <= 64'(cr) * 64'(cp);
        pb_reg  <= 64'(sr) * 64'(sp);
        pc_reg  <= 64'(sr) * 64'(cp);
        pd_reg  <= 64'(cr) * 64'(sp);
        cy1_reg <= cy;
        sy1_reg <= sy;

        ra_reg  <= Q_W'(rnd30(pa_reg));
        rb_reg  <= Q_W'(rnd30(pb_reg));
        rc_reg  <= Q_W'(rnd30(pc_reg));
        rd_reg  <= Q_W'(rnd30(pd_reg));
        cy2_reg <= cy1_reg;
        sy2_reg <= sy1_reg;

        wa_reg  <= 64'(ra_reg) * 64'(cy2_reg);
        wb_reg  <= 64'(rb_reg) * 64'(sy2_reg);
        xa_reg  <= 64'(rc_reg) * 64'(cy2_reg);
        xb_reg  <= 64'(rd_reg) * 64'(sy2_reg);
        ya_reg  <= 64'(rd_reg) * 64'(cy2_reg);
        yb_reg  <= 64'(rc_reg) * 64'(sy2_reg);
        za_reg  <= 64'(ra_reg) * 64'(sy2_reg);
        zb_reg  <= 64'(rb_reg) * 64'(cy2_reg);

        sw_reg  <= rnd30(wa_reg) + rnd30(wb_reg);
        sx_reg  <= rnd30(xa_reg) - rnd30(xb_reg);
        sy_reg  <= rnd30(ya_reg) + rnd30(yb_reg);
        sz_reg  <= rnd30(za_reg) - rnd30(zb_reg);

        qw_reg  <= fin(sw_reg);
        qx_reg  <= fin(sx_reg);
        qy_reg  <= fin(sy_reg);
        qz_reg  <= fin(sz_reg);
    end

    assign out_valid = valid_reg[4];
    assign qw = qw_reg;
    assign qx = qx_reg;
    assign qy = qy_reg;
    assign qz = qz_reg;

endmodule

>>> hdl/euler_to_quaternion.sv
// ---------------------------------------------------------------------------
// euler_to_quaternion
// roll, pitch, yaw in millidegrees to a zyx unit quaternion
// ---------------------------------------------------------------------------
// One item is taken on every clock where start is high; busy is always low.
// Each item gives one result on done after it has passed the half-angle
// scaling registers, one cordic register per micro-rotation plus a rounding
// register, and the product and rounding registers of the quaternion stage.
// The result is shown for one clock only and cannot be held off, so the
// receiver must capture it when done is high.
module euler_to_quaternion #(
    parameter int CORDIC_STAGES = e2q_pkg::CORDIC_STAGES_DEF,
    parameter int FRACTION_BITS = e2q_pkg::FRACTION_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [e2q_pkg::ANGLE_W-1:0] roll_angle,
    input  logic signed [e2q_pkg::ANGLE_W-1:0] pitch_angle,
    input  logic signed [e2q_pkg::ANGLE_W-1:0] yaw_angle,
    output logic                               done,
    output logic signed [e2q_pkg::Q_W-1:0]     quat_w,
    output logic signed [e2q_pkg::Q_W-1:0]     quat_x,
    output logic signed [e2q_pkg::Q_W-1:0]     quat_y,
    output logic signed [e2q_pkg::Q_W-1:0]     quat_z
);
    import e2q_pkg::*;

    logic                     ha_valid [3];
    logic signed [BANG_W-1:0] ha_angle [3];
    logic                     cs_valid [3];
    logic signed [Q_W-1:0]    cs_cos [3];
    logic signed [Q_W-1:0]    cs_sin [3];
    logic signed [ANGLE_W-1:0] angles [3];

    assign busy      = 1'b0;
    assign angles[0] = roll_angle;
    assign angles[1] = pitch_angle;
    assign angles[2] = yaw_angle;

    // one half-angle and cordic lane per axis
    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        e2q_half_angle u_half (
            .clk        (clk),
            .rst_n      (rst_n),
            .in_valid   (start),
            .angle_mdeg (angles[a]),
            .out_valid  (ha_valid[a]),
            .out_angle  (ha_angle[a])
        );

        e2q_cordic #(
            .CORDIC_STAGES (CORDIC_STAGES)
        ) u_cordic (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (ha_valid[a]),
            .in_angle  (ha_angle[a]),
            .out_valid (cs_valid[a]),
            .out_cos   (cs_cos[a]),
            .out_sin   (cs_sin[a])
        );
    end

    // lanes run in lockstep, so the three valids always agree
    e2q_quat #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_quat (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cs_valid[0] & cs_valid[1] & cs_valid[2]),
        .cr        (cs_cos[0]),
        .sr        (cs_sin[0]),
        .cp        (cs_cos[1]),
        .sp        (cs_sin[1]),
        .cy        (cs_cos[2]),
        .sy        (cs_sin[2]),
        .out_valid (done),
        .qw        (quat_w),
        .qx        (quat_x),
        .qy        (quat_y),
        .qz        (quat_z)
    );

endmodule

>>> hdl/e2q_checker.sv
// ---------------------------------------------------------------------------
// e2q_checker
// port-level checks of the euler to quaternion pipeline
// ---------------------------------------------------------------------------
`include "euler_to_quaternion_assert.svh"

module e2q_checker #(
    parameter int CORDIC_STAGES = e2q_pkg::CORDIC_STAGES_DEF,
    parameter int FRACTION_BITS = e2q_pkg::FRACTION_BITS_DEF
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               done,
    input logic signed [e2q_pkg::Q_W-1:0]     quat_w,
    input logic signed [e2q_pkg::Q_W-1:0]     quat_x,
    input logic signed [e2q_pkg::Q_W-1:0]     quat_y,
    input logic signed [e2q_pkg::Q_W-1:0]     quat_z
);
    import e2q_pkg::*;

    localparam int LAT = e2q_latency(CORDIC_STAGES);
    localparam logic signed [Q_W:0] LIM = (Q_W + 1)'(1) <<< FRACTION_BITS;

    logic signed [Q_W:0] w_ext;
    logic signed [Q_W:0] x_ext;
    logic signed [Q_W:0] y_ext;
    logic signed [Q_W:0] z_ext;
    logic                w_ok;
    logic                xyz_ok;

    // sign-extended outputs and range flags
    assign w_ext  = (Q_W + 1)'(quat_w);
    assign x_ext  = (Q_W + 1)'(quat_x);
    assign y_ext  = (Q_W + 1)'(quat_y);
    assign z_ext  = (Q_W + 1)'(quat_z);
    assign w_ok   = (w_ext <= LIM) && (w_ext >= -LIM);
    assign xyz_ok = (x_ext <= LIM) && (x_ext >= -LIM)
                 && (y_ext <= LIM) && (y_ext >= -LIM)
                 && (z_ext <= LIM) && (z_ext >= -LIM);

    // pipeline never pushes back
    `E2Q_ASSERT_NEVER(a_never_busy, busy, "busy raised")

    // every result traces back to an item taken at the fixed latency
    `E2Q_ASSERT_IMPLY(a_done_source, done, $past(start && !busy, LAT), "result without item")

    // results stay within plus or minus one
    `E2Q_ASSERT_IMPLY(a_w_range, done, w_ok, "w out of range")

    `E2Q_ASSERT_IMPLY(a_xyz_range, done, xyz_ok, "vector part out of range")

endmodule

bind euler_to_quaternion e2q_checker #(
    .CORDIC_STAGES (CORDIC_STAGES),
    .FRACTION_BITS (FRACTION_BITS)
) u_e2q_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .quat_w     (quat_w),
    .quat_x     (quat_x),
    .quat_y     (quat_y),
    .quat_z     (quat_z)
);

>>> tb/sv/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// drives euler angle items into euler_to_quaternion in random bursts and
// checks every quaternion against a bit-exact cordic predictor
// ---------------------------------------------------------------------------
module testbench;

    localparam int STAGES    = e2q_pkg::CORDIC_STAGES_DEF;
    localparam int FRAC      = e2q_pkg::FRACTION_BITS_DEF;
    localparam int N_RANDOM  = 1300;
    localparam int DRAIN     = STAGES + 40;
    localparam longint LIMIT = 400000;

    typedef struct packed {
        logic signed [18:0] roll;
        logic signed [18:0] pitch;
        logic signed [18:0] yaw;
    } angles_t;

    typedef struct packed {
        logic signed [31:0] w;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } quat_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [18:0] roll_angle;
    logic signed [18:0] pitch_angle;
    logic signed [18:0] yaw_angle;
    logic               done;
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;

    angles_t pending_angles[$];
    quat_t   expected_quats[$];
    int      mismatch_count;
    bit      stim_loaded;
    bit      drain_done;
    int      burst_left;
    int      gap_left;
    longint  cycle_count;

    euler_to_quaternion u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .roll_angle  (roll_angle),
        .pitch_angle (pitch_angle),
        .yaw_angle   (yaw_angle),
        .done        (done),
        .quat_w      (quat_w),
        .quat_x      (quat_x),
        .quat_y      (quat_y),
        .quat_z      (quat_z)
    );

    // clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // arithmetic shift right, floor
    function automatic longint shr_floor(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint round_q(input longint v, input int s);
        if (s == 0)
            return v;
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    // saturated millidegrees to half-angle in binary angle units
    function automatic longint to_half_turns(input logic signed [18:0] a_in);
        longint a;
        longint mag;
        longint q;
        a = a_in;
        if (a > 180000)
            a = 180000;
        if (a < -180000)
            a = -180000;
        mag = (a < 0) ? -a : a;
        q = (mag * (longint'(1) << 28) + 22500) / 45000;
        return (a < 0) ? -q : q;
    endfunction

    // rotation-mode cordic giving q30 cosine and sine
    function automatic void cordic_cos_sin(input longint ang, output longint c,
                                           output longint s);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        int     sh;
        x = longint'(e2q_pkg::GAIN_Q32);
        y = 0;
        z = ang;
        for (int i = 0; i < STAGES; i++)
        begin
            sh = i % 32;
            dx = shr_floor(y, sh);
            dy = shr_floor(x, sh);
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= longint'(e2q_pkg::ATAN_TURNS[sh]);
            end
            else
            begin
                x += dx;
                y -= dy;
                z += longint'(e2q_pkg::ATAN_TURNS[sh]);
            end
        end
        c = round_q(x, 2);
        s = round_q(y, 2);
    endfunction

    function automatic longint triple_product(input longint a, input longint b,
                                              input longint c);
        return round_q(round_q(a * b, 30) * c, 30);
    endfunction

    function automatic logic signed [31:0] to_output(input longint v);
        longint lim;
        lim = longint'(1) << FRAC;
        v = round_q(v, 30 - FRAC);
        if (v > lim)
            v = lim;
        if (v < -lim)
            v = -lim;
        return v[31:0];
    endfunction

    function automatic quat_t predict_quat(input angles_t a);
        longint cr, sr, cp, sp, cy, sy;
        quat_t  q;
        cordic_cos_sin(to_half_turns(a.roll), cr, sr);
        cordic_cos_sin(to_half_turns(a.pitch), cp, sp);
        cordic_cos_sin(to_half_turns(a.yaw), cy, sy);
        q.w = to_output(triple_product(cr, cp, cy) + triple_product(sr, sp, sy));
        q.x = to_output(triple_product(sr, cp, cy) - triple_product(cr, sp, sy));
        q.y = to_output(triple_product(cr, sp, cy) + triple_product(sr, cp, sy));
        q.z = to_output(triple_product(cr, cp, sy) - triple_product(sr, sp, cy));
        return q;
    endfunction

    function automatic logic signed [18:0] rand_angle();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 19'($urandom);
        if (pick == 1)
            return 19'($urandom_range(0, 20) - 10 + 180000 * ($urandom_range(0, 1) ? 1 : -1));
        return 19'(int'($urandom_range(0, 360000)) - 180000);
    endfunction

    function automatic angles_t make_angles(input int r, input int p, input int y);
        angles_t a;
        a.roll  = 19'(r);
        a.pitch = 19'(p);
        a.yaw   = 19'(y);
        return a;
    endfunction

    // append one item to the pending queue
    function automatic void add_item(input angles_t a);
        pending_angles.insert(pending_angles.size(), a);
    endfunction

    // stimulus: directed corners then random angles
    initial
    begin
        int corners[8];
        corners = '{0, 180000, -180000, 90000, -90000, 262143, -262144, 45000};
        for (int i = 0; i < 8; i++)
            add_item(make_angles(corners[i], 0, 0));
        for (int i = 0; i < 8; i++)
            add_item(make_angles(0, corners[i], 0));
        for (int i = 0; i < 8; i++)
            add_item(make_angles(0, 0, corners[i]));
        add_item(make_angles(180001, -180001, 1));
        for (int i = 0; i < N_RANDOM; i++)
            add_item(make_angles(rand_angle(), rand_angle(), rand_angle()));
        stim_loaded = 1'b1;
    end

    // reset and end of run
    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        while (!(stim_loaded && pending_angles.size() == 0 && !start))
            @(posedge clk);
        while (expected_quats.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (mismatch_count == 0 && expected_quats.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // driver: bursts and gaps, one pause to drain the pipeline
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start       <= 1'b0;
            roll_angle  <= '0;
            pitch_angle <= '0;
            yaw_angle   <= '0;
            burst_left  <= 0;
            gap_left    <= 0;
            drain_done  <= 1'b0;
        end
        else
        begin
            automatic bit send  = 1'b0;
            automatic bit pause = 1'b0;
            if (start && !busy)
                expected_quats.insert(expected_quats.size(),
                                      predict_quat({roll_angle, pitch_angle, yaw_angle}));
            // hold once 700 items remain until every expected result is back
            pause = !drain_done && pending_angles.size() == 700;
            if (pause && !start && expected_quats.size() == 0)
                drain_done <= 1'b1;
            if (start && busy)
                send = 1'b1;
            else if (!pause && pending_angles.size() != 0)
            begin
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
                else if (burst_left > 0)
                begin
                    send = 1'b1;
                    burst_left <= burst_left - 1;
                end
                else
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            if (send && !(start && busy))
            begin
                automatic angles_t a = pending_angles.pop_front();
                roll_angle  <= a.roll;
                pitch_angle <= a.pitch;
                yaw_angle   <= a.yaw;
            end
            start <= send;
        end
    end

    // monitor: compare each result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_quats.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result w=%0d x=%0d y=%0d z=%0d",
                             quat_w, quat_x, quat_y, quat_z);
            end
            else
            begin
                automatic quat_t e = expected_quats.pop_front();
                if (e.w !== quat_w || e.x !== quat_x || e.y !== quat_y || e.z !== quat_z)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                                 e.w, e.x, e.y, e.z, quat_w, quat_x, quat_y, quat_z);
                end
            end
        end
    end

endmodule
